>>> hw/rtl/wsg_pkg.sv
// ----------------------------------------------------------------------------
// wsg_pkg
// Shared types, constants and the quarter sine table of the waveform
// sample generator.
// ----------------------------------------------------------------------------
package wsg_pkg;

	typedef logic [6:0] phase_t;

	localparam phase_t LAST_PHASE = 7'd99;
	localparam phase_t HALF_PHASE = 7'd50;
	localparam phase_t QUARTER_PHASE = 7'd25;

	typedef enum logic [1:0] {
		WAVE_SINE     = 2'd0,
		WAVE_TRIANGLE = 2'd1,
		WAVE_SAWTOOTH = 2'd2,
		WAVE_SQUARE   = 2'd3
	} wave_t;

	// register indexes on the configuration port
	localparam logic [1:0] REG_WAVEFORM  = 2'd0;
	localparam logic [1:0] REG_AMPLITUDE = 2'd1;
	localparam logic [1:0] REG_OFFSET    = 2'd2;

	typedef struct packed {
		wave_t              waveform;
		logic [13:0]        amplitude;
		logic signed [13:0] offset;
	} cfg_t;

	localparam logic [13:0] AMPLITUDE_RESET = 14'd10000;
	localparam logic [13:0] MIDPOINT        = 14'd5000;
	localparam logic [13:0] FULL_SCALE      = 14'd10000;

	// amplitude / 100 as (amplitude * 5243) >> 19, exact for 14-bit inputs
	localparam logic [12:0] AMP_RECIP = 13'd5243;
	localparam int unsigned AMP_SHIFT = 19;

	// 65535 * v / 10000 as (v * 879595881) >> 27, exact for v up to 10000
	localparam logic [29:0] DAC_RECIP = 30'd879595881;
	localparam int unsigned DAC_SHIFT = 27;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);

	// trunc(sin(2*pi*m/100) * 50) for m = 0..25
	function automatic logic [5:0] quarter_sine(input logic [4:0] m);
		logic [5:0] q;
		case (m)
			5'd0:  q = 6'd0;
			5'd1:  q = 6'd3;
			5'd2:  q = 6'd6;
			5'd3:  q = 6'd9;
			5'd4:  q = 6'd12;
			5'd5:  q = 6'd15;
			5'd6:  q = 6'd18;
			5'd7:  q = 6'd21;
			5'd8:  q = 6'd24;
			5'd9:  q = 6'd26;
			5'd10: q = 6'd29;
			5'd11: q = 6'd31;
			5'd12: q = 6'd34;
			5'd13: q = 6'd36;
			5'd14: q = 6'd38;
			5'd15: q = 6'd40;
			5'd16: q = 6'd42;
			5'd17: q = 6'd43;
			5'd18: q = 6'd45;
			5'd19: q = 6'd46;
			5'd20: q = 6'd47;
			5'd21: q = 6'd48;
			5'd22: q = 6'd49;
			5'd23: q = 6'd49;
			5'd24: q = 6'd49;
			5'd25: q = 6'd50;
			default: q = 6'd0;
		endcase
		return q;
	endfunction

endpackage

>>> hw/rtl/wsg_cfg.sv
// ----------------------------------------------------------------------------
// wsg_cfg
// Configuration registers: shape select, amplitude and offset.
// ----------------------------------------------------------------------------
module wsg_cfg import wsg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [13:0] cfg_data,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.waveform  <= WAVE_SINE;
			cfg_q.amplitude <= AMPLITUDE_RESET;
			cfg_q.offset    <= 14'sd0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_WAVEFORM:  cfg_q.waveform  <= wave_t'(cfg_data[1:0]);
				REG_AMPLITUDE: cfg_q.amplitude <= cfg_data;
				REG_OFFSET:    cfg_q.offset    <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

endmodule

>>> hw/rtl/wsg_front.sv
// ----------------------------------------------------------------------------
// wsg_front
// Accepts ticks, keeps the phase counter and queues one phase per tick.
// ----------------------------------------------------------------------------
module wsg_front import wsg_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_stall,
	input  logic   tick,
	input  logic   q_full,
	output logic   push,
	output phase_t push_phase
);

	phase_t phase_q;

	assign in_stall = q_full;
	// a transfer with tick low is taken and dropped
	assign push = in_valid && !q_full && tick;
	assign push_phase = phase_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (push) begin
			phase_q <= (phase_q >= LAST_PHASE) ? '0 : phase_q + 7'd1;
		end
	end

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= LAST_PHASE)
		else $error("phase counter out of range");

endmodule

>>> hw/rtl/wsg_queue.sv
// ----------------------------------------------------------------------------
// wsg_queue
// Short queue of phase indexes between the front and the sample pipeline.
// ----------------------------------------------------------------------------
module wsg_queue import wsg_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  phase_t push_data,
	input  logic   pop,
	output phase_t pop_data,
	output logic   full,
	output logic   empty
);

	phase_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QPTR_W:0]     count_q;

	assign full = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop)
		else $error("pop from empty queue");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count lost a push");

endmodule

>>> hw/rtl/wsg_back.sv
// ----------------------------------------------------------------------------
// wsg_back
// Three-stage sample pipeline: shape factor, level, clip and DAC scaling.
// ----------------------------------------------------------------------------
module wsg_back import wsg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        q_empty,
	input  phase_t      q_data,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] dac_code,
	output logic [6:0]  sample_index
);

	logic advance;

	// stage 1 inputs
	logic [26:0]        amp_prod;
	logic [7:0]         step;
	logic [14:0]        off_adj;
	logic [13:0]        half_off;
	phase_t             fold;
	phase_t             mirror;
	logic [5:0]         sine_mag;
	logic [7:0]         twice_n;
	logic [7:0]         tri_up;
	logic [7:0]         tri_down;
	logic [6:0]         factor;
	logic [7:0]         mult_step;
	logic               low_half;

	// stage 2 inputs
	logic signed [15:0] f_ext;
	logic signed [15:0] a_ext;
	logic signed [15:0] swing;
	logic signed [16:0] level;

	// stage 3 inputs
	logic [13:0]        clipped;

	logic               v_s1, v_s2, v_s3;
	phase_t             idx_s1, idx_s2, idx_s3;
	logic signed [6:0]  factor_s1;
	logic [7:0]         step_s1;
	logic [13:0]        center_s1;
	logic signed [16:0] level_s2;
	logic [43:0]        scaled_s3;

	// whole pipe moves unless the result is held by the receiver
	assign advance = !v_s3 || !out_stall;
	assign pop = advance && !q_empty;

	always_comb begin
		amp_prod = {13'd0, cfg.amplitude} * {14'd0, AMP_RECIP};
		step = amp_prod[AMP_SHIFT +: 8];

		// offset halved toward zero
		off_adj = {cfg.offset[13], cfg.offset} + {14'd0, cfg.offset[13]};
		half_off = off_adj[14:1];

		low_half = (q_data < HALF_PHASE);
		fold = low_half ? q_data : q_data - HALF_PHASE;
		mirror = (fold > QUARTER_PHASE) ? HALF_PHASE - fold : fold;
		sine_mag = quarter_sine(mirror[4:0]);

		twice_n = {q_data, 1'b0};
		tri_up = twice_n - 8'd50;
		tri_down = 8'd150 - twice_n;

		mult_step = step;
		case (cfg.waveform)
			WAVE_SINE:     factor = low_half ? {1'b0, sine_mag} : 7'd0 - {1'b0, sine_mag};
			WAVE_TRIANGLE: factor = low_half ? tri_up[6:0] : tri_down[6:0];
			WAVE_SAWTOOTH: factor = q_data - HALF_PHASE;
			WAVE_SQUARE: begin
				// (a/2)*100 is (a with lsb cleared) * 50
				factor = low_half ? 7'd50 : 7'd0 - 7'd50;
				mult_step = {step[7:1], 1'b0};
			end
			default:       factor = '0;
		endcase
	end

	always_comb begin
		f_ext = {{9{factor_s1[6]}}, factor_s1};
		a_ext = {8'd0, step_s1};
		swing = f_ext * a_ext;
		level = $signed({3'b000, center_s1}) + {swing[15], swing};
	end

	always_comb begin
		if (level_s2[16]) begin
			clipped = '0;
		end else if (level_s2 > $signed({3'b000, FULL_SCALE})) begin
			clipped = FULL_SCALE;
		end else begin
			clipped = level_s2[13:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (advance) begin
			v_s1 <= !q_empty;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			idx_s1    <= q_data;
			factor_s1 <= $signed(factor);
			step_s1   <= mult_step;
			center_s1 <= MIDPOINT - half_off;
			idx_s2    <= idx_s1;
			level_s2  <= level;
			idx_s3    <= idx_s2;
			scaled_s3 <= {30'd0, clipped} * {14'd0, DAC_RECIP};
		end
	end

	assign out_valid = v_s3;
	assign dac_code = scaled_s3[DAC_SHIFT +: 16];
	assign sample_index = idx_s3;

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (idx_s3 <= LAST_PHASE))
		else $error("emitted sample index out of range");

	a_pop_loads: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> v_s1)
		else $error("popped phase did not enter the pipeline");

endmodule

>>> hw/rtl/waveform_sample_generator.sv
// ----------------------------------------------------------------------------
// waveform_sample_generator
// Table-style waveform generator: one DAC code per sample tick.
// ----------------------------------------------------------------------------
// Input channel (in_valid, in_stall, tick): each transfer with tick high
// emits one sample for the current phase and steps the phase 0..99; a
// transfer with tick low is taken and produces nothing.
// Output channel (out_valid, out_stall, dac_code, sample_index): the DAC
// code clipped to 0..10000 and scaled to 0..65535, with its phase.
// Configuration (cfg_valid, cfg_ready, cfg_index, cfg_data): index 0 shape,
// 1 amplitude, 2 offset; cfg_ready is always high, index 3 is ignored.
// A sample passes the queue, then three pipeline registers, on its way
// out. Throughput: one sample per cycle while out_stall is low.
// When out_stall is held the pipeline freezes, the four-entry phase queue
// fills and in_stall then rises; nothing is dropped.
// Reset: phase 0, sine shape, amplitude 10000, offset 0, pipeline empty.
// ----------------------------------------------------------------------------
module waveform_sample_generator import wsg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        tick,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] dac_code,
	output logic [6:0]  sample_index,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [13:0] cfg_data
);

	cfg_t   cfg;
	logic   push;
	phase_t push_phase;
	logic   pop;
	phase_t pop_phase;
	logic   q_full;
	logic   q_empty;

	wsg_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	wsg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.tick       (tick),
		.q_full     (q_full),
		.push       (push),
		.push_phase (push_phase)
	);

	wsg_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_phase),
		.pop       (pop),
		.pop_data  (pop_phase),
		.full      (q_full),
		.empty     (q_empty)
	);

	wsg_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.q_empty      (q_empty),
		.q_data       (pop_phase),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.dac_code     (dac_code),
		.sample_index (sample_index)
	);

endmodule

>>> sim/waveform_sample_generator_tb.sv
// ----------------------------------------------------------------------------
// waveform_sample_generator_tb
// Self-checking bench for the waveform sample generator. A short list of
// directed ticks and register writes covers the shapes, the clip limits,
// offset halving and the unused register index. Random phases follow, each
// with its own register setting and idle pattern. Each sample's phase is
// checked by an in-bench predictor, its code by the table or shape math.
// ----------------------------------------------------------------------------
module waveform_sample_generator_tb import wsg_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] REG_SPARE = 2'd3;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES = 60;
	localparam int PHASE_COUNT = 24;
	localparam int TICKS_PER_PHASE = 54;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HALF_WAVE = 50;
	localparam longint DAC_TOP = 65535;

	typedef enum logic {ROW_WRITE, ROW_ITEM} row_kind_t;
	typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	typedef struct {
		row_kind_t   kind;
		logic [1:0]  reg_index;
		logic [13:0] data;
		logic        tk;
		bit          known;
		logic [15:0] code;
	} row_t;

	typedef struct {
		logic [15:0] code;
		phase_t      idx;
	} sample_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        tick;
	logic        out_valid;
	logic        out_stall;
	logic [15:0] dac_code;
	logic [6:0]  sample_index;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [13:0] cfg_data;

	// typed expectation travels beside the tick payload
	logic        code_known;
	logic [15:0] typed_code;

	wave_t              cfg_shape = WAVE_SINE;
	logic [13:0]        cfg_amp = AMPLITUDE_RESET;
	logic signed [13:0] cfg_ofs = '0;
	int                 model_phase = 0;
	sample_t            samples_due[$];

	int fail_count = 0;
	int cycle_count = 0;
	int sender_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_requests = 0;

	int sine_quarter [0:25] = '{0, 3, 6, 9, 12, 15, 18, 21, 24, 26,
		29, 31, 34, 36, 38, 40, 42, 43, 45, 46, 47, 48, 49, 49, 49, 50};

	row_t directed_rows [25] = '{
		'{ROW_ITEM,  REG_WAVEFORM,  14'd0,                 1'b1, 1'b1, 16'd32767},
		'{ROW_ITEM,  REG_WAVEFORM,  14'd0,                 1'b0, 1'b0, 16'd0},
		'{ROW_ITEM,  REG_WAVEFORM,  14'd0,                 1'b1, 1'b0, 16'd0},
		'{ROW_WRITE, REG_WAVEFORM,  {12'd0, WAVE_SQUARE},   1'b0, 1'b0, 16'd0},
		'{ROW_WRITE, REG_AMPLITUDE, 14'h3FFF,              1'b0, 1'b0, 16'd0},
		'{ROW_WRITE, REG_OFFSET,    14'h2000,              1'b0, 1'b0, 16'd0},
		'{ROW_ITEM,  REG_WAVEFORM,  14'd0,                 1'b1, 1'b1, 16'd65535},
		'{ROW_ITEM,  REG_WAVEFORM,  14'd0,                 1'b0, 1'b0, 16'd0},
		'{ROW_WRITE, REG_OFFSET,    14'h1FFF,              1'b0, 1'b0, 16'd0},
		'{ROW_ITEM,  REG_WAVEFORM,  14'd0,                 1'b1, 1'b0, 16'd0},
		'{ROW_WRITE, REG_WAVEFORM,  {12'd0, WAVE_TRIANGLE}, 1'b0, 1'b0, 16'd0},
		'{ROW_ITEM,  REG_WAVEFORM,  14'd0,                 1'b1, 1'b1, 16'd0},
		'{ROW_WRITE, REG_WAVEFORM,  {12'd0, WAVE_SAWTOOTH}, 1'b0, 1'b0, 16'd0},
		'{ROW_WRITE, REG_AMPLITUDE, 14'd0,                 1'b0, 1'b0, 16'd0},
		'{ROW_WRITE, REG_OFFSET,    14'h3FFF,              1'b0, 1'b0, 16'd0},
		'{ROW_ITEM,  REG_WAVEFORM,  14'd0,                 1'b1, 1'b1, 16'd32767},
		'{ROW_WRITE, REG_SPARE,     14'h3FFF,              1'b0, 1'b0, 16'd0},
		'{ROW_ITEM,  REG_WAVEFORM,  14'd0,                 1'b1, 1'b1, 16'd32767},
		'{ROW_WRITE, REG_AMPLITUDE, 14'd10000,             1'b0, 1'b0, 16'd0},
		'{ROW_WRITE, REG_OFFSET,    14'h3FFD,              1'b0, 1'b0, 16'd0},
		'{ROW_ITEM,  REG_WAVEFORM,  14'd0,                 1'b1, 1'b0, 16'd0},
		'{ROW_WRITE, REG_SPARE,     14'h0000,              1'b0, 1'b0, 16'd0},
		'{ROW_ITEM,  REG_WAVEFORM,  14'd0,                 1'b1, 1'b0, 16'd0},
		'{ROW_WRITE, REG_WAVEFORM,  {12'd0, WAVE_SINE},     1'b0, 1'b0, 16'd0},
		'{ROW_ITEM,  REG_WAVEFORM,  14'd0,                 1'b1, 1'b0, 16'd0}
	};

	waveform_sample_generator DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.tick(tick),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.dac_code(dac_code),
		.sample_index(sample_index),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic int sine_step(int n);
		int m;
		m = n % HALF_WAVE;
		if (m > 25) m = HALF_WAVE - m;
		return (n >= HALF_WAVE) ? -sine_quarter[m] : sine_quarter[m];
	endfunction

	function automatic logic [15:0] dac_for_phase(int n);
		int a, h, c, v;
		a = int'(cfg_amp) / 100;
		h = int'(cfg_ofs) / 2;
		c = int'(MIDPOINT) - h;
		case (cfg_shape)
			WAVE_SINE: v = c + sine_step(n) * a;
			WAVE_TRIANGLE: v = (n < HALF_WAVE) ? c + a * (2 * n - 50) : c + a * (150 - 2 * n);
			WAVE_SAWTOOTH: v = c + (n - HALF_WAVE) * a;
			default: begin
				if (n < HALF_WAVE) v = int'(MIDPOINT) + (a / 2) * 100 - h;
				else v = int'(MIDPOINT) - (a / 2) * 100 - h;
			end
		endcase
		if (v > int'(FULL_SCALE)) v = int'(FULL_SCALE);
		else if (v < 0) v = 0;
		return 16'((DAC_TOP * longint'(v)) / longint'(FULL_SCALE));
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	// register writes, tick transfers and sample transfers, all seen at the edge
	always @(posedge clk) begin : watch
		sample_t due;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_WAVEFORM: cfg_shape = wave_t'(cfg_data[1:0]);
					REG_AMPLITUDE: cfg_amp = cfg_data;
					REG_OFFSET: cfg_ofs = signed'(cfg_data);
					default: ;
				endcase
			end
			if (in_valid && !in_stall && tick) begin
				due.code = code_known ? typed_code : dac_for_phase(model_phase);
				due.idx = phase_t'(model_phase);
				samples_due.push_back(due);
				model_phase = (model_phase == int'(LAST_PHASE)) ? 0 : model_phase + 1;
			end
			if (out_valid && !out_stall) begin
				if (samples_due.size() == 0) begin
					report_mismatch("sample with none due, dac_code", dac_code, -1);
				end else begin
					due = samples_due.pop_front();
					if (dac_code !== due.code) report_mismatch("dac_code", dac_code, due.code);
					if (sample_index !== due.idx)
						report_mismatch("sample_index", sample_index, due.idx);
				end
			end
		end
	end

	// receiver: random stalls, plus a long hold-off on request
	initial begin : receiver
		int hold_left;
		int holds_done;
		hold_left = 0;
		holds_done = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left == 0 && holds_done != hold_requests) begin
				hold_left = HOLD_CYCLES;
				holds_done++;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", CYCLE_LIMIT);
			$display("waveform_sample_generator_tb NOT OK");
			$finish;
		end
	end

	task automatic offer_tick(input logic tk, input bit known, input logic [15:0] code);
		if ($urandom_range(0, 99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			tick <= 1'($urandom_range(0, 1));
			do @(posedge clk); while ($urandom_range(0, 99) < sender_idle_pct);
		end
		in_valid <= 1'b1;
		tick <= tk;
		code_known <= known;
		typed_code <= code;
		do @(posedge clk); while (in_stall);
	endtask

	// let every due sample leave, plus time for tick-low transfers in flight
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (samples_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [13:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [13:0] pick_amplitude();
		case ($urandom_range(0, 5))
			0: return 14'd0;
			1: return 14'h3FFF;
			2: return AMPLITUDE_RESET;
			3: return 14'(100 * $urandom_range(0, 163));
			4: return 14'($urandom_range(0, 200));
			default: return 14'($urandom_range(0, 16383));
		endcase
	endfunction

	function automatic logic [13:0] pick_offset();
		case ($urandom_range(0, 6))
			0: return 14'h2000;
			1: return 14'h1FFF;
			2: return 14'(-5000);
			3: return 14'd5000;
			4: return 14'($signed($urandom_range(0, 6)) - 3);
			default: return 14'($urandom_range(0, 16383));
		endcase
	endfunction

	initial begin : stimulus
		int ph;
		int sent;
		idle_mode_t mode;
		arst_n = 1'b0;
		in_valid = 1'b0;
		tick = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_WAVEFORM;
		cfg_data = '0;
		code_known = 1'b0;
		typed_code = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r]) begin
			if (directed_rows[r].kind == ROW_WRITE) begin
				drain();
				write_reg(directed_rows[r].reg_index, directed_rows[r].data);
			end else begin
				offer_tick(directed_rows[r].tk, directed_rows[r].known, directed_rows[r].code);
			end
		end

		for (ph = 0; ph < PHASE_COUNT; ph++) begin
			drain();
			write_reg(REG_WAVEFORM, {12'd0, 2'(ph % 4)});
			write_reg(REG_AMPLITUDE, pick_amplitude());
			write_reg(REG_OFFSET, pick_offset());
			if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, 14'($urandom_range(0, 16383)));
			mode = idle_mode_t'((ph / 4) % 4);
			sender_idle_pct = (mode == IDLE_SENDER) ? 62 : (mode == IDLE_BOTH) ? 12 : 0;
			recv_stall_pct <= (mode == IDLE_RECEIVER) ? 62 : (mode == IDLE_BOTH) ? 12 : 0;
			// fill the block against a receiver that holds off
			if (ph == 2 || ph == 13) hold_requests <= hold_requests + 1;
			sent = 0;
			while (sent < TICKS_PER_PHASE) begin
				if ($urandom_range(0, 9) == 0) begin
					offer_tick(1'b0, 1'b0, 16'd0);
				end else begin
					offer_tick(1'b1, 1'b0, 16'd0);
					sent++;
				end
			end
		end

		drain();
		if (samples_due.size() != 0) report_mismatch("samples never emitted", samples_due.size(), 0);
		if (fail_count == 0) begin
			$display("waveform_sample_generator_tb OK");
		end else begin
			$display("waveform_sample_generator_tb NOT OK");
		end
		$finish;
	end

endmodule
